/* hw/rtl/qrs_pkg.sv */
package qrs_pkg;

  localparam int OUT_W    = 32;
  localparam int OUT_FRAC = 16;

  localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

endpackage

/* hw/rtl/qrs_coef_if.sv */
interface qrs_coef_if #(
  parameter int COEFF_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COEFF_WIDTH-1:0] coef_a;
  logic signed [COEFF_WIDTH-1:0] coef_b;
  logic signed [COEFF_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

/* hw/rtl/qrs_root_if.sv */
interface qrs_root_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic               is_complex;
  logic               lead_zero_error;
  logic               saturated;

  modport source (output valid, first_value, second_value, is_complex, lead_zero_error,
                  saturated, input ready);
  modport sink   (input valid, first_value, second_value, is_complex, lead_zero_error,
                  saturated, output ready);
endinterface

/* hw/rtl/quadratic_root_solver.sv */
// Roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients. The
// discriminant b^2 - 4ac is formed exactly; real roots come out as
// (-b +/- sqrt(d))/(2a), a negative discriminant gives the real part and the
// imaginary magnitude with is_complex set. Results are signed Q16.16, clipped
// with saturated set; a zero coefficient a gives zero values and
// lead_zero_error. One coefficient set is taken every cycle. The pipeline
// has two stages for the products and discriminant, COEFF_WIDTH+1
// square-root stages, one stage for the numerators, COEFF_WIDTH+17 divider
// stages and the output register. The whole pipeline holds while a result
// waits on out_ch.
module quadratic_root_solver #(
  parameter int COEFF_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  qrs_coef_if.sink      in_ch,
  qrs_root_if.source    out_ch
);
  import qrs_pkg::*;

  localparam int W   = COEFF_WIDTH;
  localparam int DW  = 2 * W + 2;
  localparam int R   = W + 1;
  localparam int MW  = W + 1;
  localparam int NW  = MW + OUT_FRAC;
  localparam int DVW = W + 1;
  localparam int SSW = W + DVW + 3;
  localparam int DSW = 4;

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: products
  logic             v1;
  logic [2*W-1:0]   pp1;
  logic [2*W-1:0]   qq1;
  logic             add1;
  logic signed [W-1:0] b1;
  logic [W-1:0]     am1;
  logic             aneg1;
  logic             zero1;
  logic [W-1:0]     am;
  logic [W-1:0]     bm;
  logic [W-1:0]     cm;

  always_comb begin
    am = in_ch.coef_a[W-1] ? W'(-in_ch.coef_a) : in_ch.coef_a;
    bm = in_ch.coef_b[W-1] ? W'(-in_ch.coef_b) : in_ch.coef_b;
    cm = in_ch.coef_c[W-1] ? W'(-in_ch.coef_c) : in_ch.coef_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
    end
    if (en) begin
      pp1   <= bm * bm;
      qq1   <= am * cm;
      add1  <= (in_ch.coef_c != '0) && (in_ch.coef_a[W-1] != in_ch.coef_c[W-1]);
      b1    <= in_ch.coef_b;
      am1   <= am;
      aneg1 <= in_ch.coef_a[W-1];
      zero1 <= in_ch.coef_a == '0;
    end
  end

  // stage 2: discriminant
  logic             v2;
  logic [DW-1:0]    d2;
  logic             dneg2;
  logic signed [W-1:0] b2;
  logic [DVW-1:0]   den2;
  logic             aneg2;
  logic             zero2;
  logic [DW-1:0]    p_x;
  logic [DW-1:0]    q4_x;

  always_comb begin
    p_x  = {2'b00, pp1};
    q4_x = {qq1, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      if (add1) begin
        d2    <= p_x + q4_x;
        dneg2 <= 1'b0;
      end else if (p_x >= q4_x) begin
        d2    <= p_x - q4_x;
        dneg2 <= 1'b0;
      end else begin
        d2    <= q4_x - p_x;
        dneg2 <= 1'b1;
      end
      b2    <= b1;
      den2  <= {am1, 1'b0};
      aneg2 <= aneg1;
      zero2 <= zero1;
    end
  end

  // square root
  logic            vs;
  logic [R-1:0]    rs;
  logic [SSW-1:0]  sside;

  qrs_sqrt #(.DW(DW), .SW(SSW)) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v2),
    .d       (d2),
    .side    ({b2, den2, aneg2, dneg2, zero2}),
    .out_vld (vs),
    .root    (rs),
    .side_o  (sside)
  );

  // stage 3: numerators
  logic signed [W-1:0] bs;
  logic [DVW-1:0]      dens;
  logic                anegs;
  logic                dnegs;
  logic                zeros;
  logic signed [W+1:0] bx;
  logic signed [W+1:0] sx;
  logic signed [W+1:0] n1;
  logic signed [W+1:0] n2;
  logic [W+1:0]        n1m;
  logic [W+1:0]        n2m;

  always_comb begin
    {bs, dens, anegs, dnegs, zeros} = sside;
    bx  = (W+2)'(bs);
    sx  = $signed({1'b0, rs});
    n1  = dnegs ? -bx : sx - bx;
    n2  = dnegs ? sx : -bx - sx;
    n1m = n1[W+1] ? (W+2)'(-n1) : n1;
    n2m = n2[W+1] ? (W+2)'(-n2) : n2;
  end

  logic            v3;
  logic [MW-1:0]   m1;
  logic [MW-1:0]   m2;
  logic [DVW-1:0]  den3;
  logic            neg1_3;
  logic            neg2_3;
  logic            dneg3;
  logic            zero3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vs;
    end
    if (en) begin
      m1     <= n1m[MW-1:0];
      m2     <= n2m[MW-1:0];
      den3   <= zeros ? DVW'(1) : dens;
      neg1_3 <= n1[W+1] ^ anegs;
      neg2_3 <= dnegs ? 1'b0 : (n2[W+1] ^ anegs);
      dneg3  <= dnegs;
      zero3  <= zeros;
    end
  end

  // divide
  logic           vd;
  logic [NW-1:0]  qa;
  logic [NW-1:0]  qb;
  logic [DSW-1:0] dside;

  qrs_div #(.NW(NW), .DVW(DVW), .SW(DSW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v3),
    .num1    ({m1, OUT_FRAC'(0)}),
    .num2    ({m2, OUT_FRAC'(0)}),
    .den     (den3),
    .side    ({neg1_3, neg2_3, dneg3, zero3}),
    .out_vld (vd),
    .quo1    (qa),
    .quo2    (qb),
    .side_o  (dside)
  );

  // saturate and output register
  logic [63:0]      qa_x;
  logic [63:0]      qb_x;
  logic [OUT_W-1:0] va;
  logic [OUT_W-1:0] vb;
  logic             sa;
  logic             sbt;

  always_comb begin
    qa_x = 64'(qa);
    qb_x = 64'(qb);
    if (dside[3]) begin
      sa = qa_x > NEG_LIMIT;
      va = sa ? NEG_LIMIT[OUT_W-1:0] : OUT_W'(-qa_x);
    end else begin
      sa = qa_x > POS_LIMIT;
      va = sa ? POS_LIMIT[OUT_W-1:0] : qa_x[OUT_W-1:0];
    end
    if (dside[2]) begin
      sbt = qb_x > NEG_LIMIT;
      vb  = sbt ? NEG_LIMIT[OUT_W-1:0] : OUT_W'(-qb_x);
    end else begin
      sbt = qb_x > POS_LIMIT;
      vb  = sbt ? POS_LIMIT[OUT_W-1:0] : qb_x[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= vd;
    end
    if (en) begin
      out_ch.first_value     <= dside[0] ? '0 : $signed(va);
      out_ch.second_value    <= dside[0] ? '0 : $signed(vb);
      out_ch.is_complex      <= dside[1] && !dside[0];
      out_ch.lead_zero_error <= dside[0];
      out_ch.saturated       <= (sa || sbt) && !dside[0];
    end
  end

  a_lead_zero_values: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.lead_zero_error |->
      out_ch.first_value == '0 && out_ch.second_value == '0)
    else $error("lead zero error with nonzero values");

  a_lead_zero_flags: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.lead_zero_error |-> !out_ch.is_complex && !out_ch.saturated)
    else $error("lead zero error with other flags");

  a_imag_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.is_complex |-> !out_ch.second_value[OUT_W-1])
    else $error("negative imaginary magnitude");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline stalled");
endmodule

/* hw/rtl/qrs_sqrt.sv */
module qrs_sqrt #(
  parameter int DW = 34,
  parameter int SW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [DW-1:0]     d,
  input  logic [SW-1:0]     side,
  output logic              out_vld,
  output logic [DW/2-1:0]   root,
  output logic [SW-1:0]     side_o
);
  localparam int R = DW / 2;

  logic            vld [0:R];
  logic [R+1:0]    rem [0:R];
  logic [R-1:0]    rt  [0:R];
  logic [DW-1:0]   dsh [0:R];
  logic [SW-1:0]   sb  [0:R];

  assign vld[0] = in_vld;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign dsh[0] = d;
  assign sb[0]  = side;

  // one root bit per stage
  for (genvar k = 1; k <= R; k++) begin : g_stg
    logic [R+3:0] rem2;
    logic [R+3:0] trial;
    logic         take;

    always_comb begin
      rem2  = {rem[k-1], dsh[k-1][DW-1 -: 2]};
      trial = {2'b00, rt[k-1], 2'b01};
      take  = rem2 >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        rem[k] <= take ? (R+2)'(rem2 - trial) : rem2[R+1:0];
        rt[k]  <= {rt[k-1][R-2:0], take};
        dsh[k] <= dsh[k-1] << 2;
        sb[k]  <= sb[k-1];
      end
    end
  end

  assign out_vld = vld[R];
  assign root    = rt[R];
  assign side_o  = sb[R];
endmodule

/* hw/rtl/qrs_div.sv */
module qrs_div #(
  parameter int NW  = 33,
  parameter int DVW = 17,
  parameter int SW  = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [NW-1:0]   num1,
  input  logic [NW-1:0]   num2,
  input  logic [DVW-1:0]  den,
  input  logic [SW-1:0]   side,
  output logic            out_vld,
  output logic [NW-1:0]   quo1,
  output logic [NW-1:0]   quo2,
  output logic [SW-1:0]   side_o
);
  logic            vld [0:NW];
  logic [NW-1:0]   n1  [0:NW];
  logic [NW-1:0]   n2  [0:NW];
  logic [DVW-1:0]  r1  [0:NW];
  logic [DVW-1:0]  r2  [0:NW];
  logic [NW-1:0]   q1  [0:NW];
  logic [NW-1:0]   q2  [0:NW];
  logic [DVW-1:0]  dv  [0:NW];
  logic [SW-1:0]   sb  [0:NW];

  assign vld[0] = in_vld;
  assign n1[0]  = num1;
  assign n2[0]  = num2;
  assign r1[0]  = '0;
  assign r2[0]  = '0;
  assign q1[0]  = '0;
  assign q2[0]  = '0;
  assign dv[0]  = den;
  assign sb[0]  = side;

  // restoring division, one quotient bit per stage, two lanes share the divisor
  for (genvar k = 1; k <= NW; k++) begin : g_stg
    logic [DVW:0] t1;
    logic [DVW:0] t2;
    logic         k1;
    logic         k2;

    always_comb begin
      t1 = {r1[k-1], n1[k-1][NW-1]};
      t2 = {r2[k-1], n2[k-1][NW-1]};
      k1 = t1 >= {1'b0, dv[k-1]};
      k2 = t2 >= {1'b0, dv[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        r1[k] <= k1 ? DVW'(t1 - {1'b0, dv[k-1]}) : t1[DVW-1:0];
        r2[k] <= k2 ? DVW'(t2 - {1'b0, dv[k-1]}) : t2[DVW-1:0];
        q1[k] <= {q1[k-1][NW-2:0], k1};
        q2[k] <= {q2[k-1][NW-2:0], k2};
        n1[k] <= n1[k-1] << 1;
        n2[k] <= n2[k-1] << 1;
        dv[k] <= dv[k-1];
        sb[k] <= sb[k-1];
      end
    end
  end

  assign out_vld = vld[NW];
  assign quo1    = q1[NW];
  assign quo2    = q2[NW];
  assign side_o  = sb[NW];
endmodule

/* sim/quadratic_root_solver_tb.sv */
`timescale 1ns / 100ps

module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int CW = 16;
  localparam int LATENCY = 2 * CW + 22;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } coef_set_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] first_value;
    logic signed [OUT_W-1:0] second_value;
    logic is_complex;
    logic lead_zero_error;
    logic saturated;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qrs_coef_if #(.COEFF_WIDTH(CW)) in_ch ();
  qrs_root_if out_ch ();

  quadratic_root_solver #(.COEFF_WIDTH(CW)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  coef_set_t pending_sets[$];
  roots_t expected_roots[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit drain_pause = 1'b0;
  bit long_hold = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] scale_divide(input logic signed [127:0] num,
                                               input logic [127:0] den, input bit flip,
                                               inout bit sat);
    logic [127:0] mag;
    logic [127:0] quo;
    bit neg;
    neg = (num < 0) != flip;
    mag = (num < 0) ? -num : num;
    quo = (mag << OUT_FRAC) / den;
    if (neg) begin
      if (quo > 128'(NEG_LIMIT)) begin
        sat = 1'b1;
        quo = 128'(NEG_LIMIT);
      end
      return 32'(-quo);
    end
    if (quo > 128'(POS_LIMIT)) begin
      sat = 1'b1;
      quo = 128'(POS_LIMIT);
    end
    return quo[31:0];
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] root;
    logic [127:0] rem;
    logic [127:0] trial;
    root = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic roots_t solve_roots(input coef_set_t s);
    roots_t r;
    logic signed [127:0] a, b, c, disc, rt;
    bit sat;
    r = '0;
    sat = 1'b0;
    a = s.a;
    b = s.b;
    c = s.c;
    if (a == 0) begin
      r.lead_zero_error = 1'b1;
      return r;
    end
    disc = b * b - 4 * a * c;
    rt = floor_sqrt(disc < 0 ? -disc : disc);
    if (disc >= 0) begin
      r.first_value = scale_divide(-b + rt, (a < 0 ? -a : a) * 2, a < 0, sat);
      r.second_value = scale_divide(-b - rt, (a < 0 ? -a : a) * 2, a < 0, sat);
    end else begin
      r.is_complex = 1'b1;
      r.first_value = scale_divide(-b, (a < 0 ? -a : a) * 2, a < 0, sat);
      r.second_value = scale_divide(rt, (a < 0 ? -a : a) * 2, 1'b0, sat);
    end
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(signed'($urandom_range(0, 8)) - 4);
      3: return 16'(signed'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 99) < 50) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.coef_a <= '0;
      in_ch.coef_b <= '0;
      in_ch.coef_c <= '0;
      gap_left <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_roots.push_back(solve_roots({in_ch.coef_a, in_ch.coef_b, in_ch.coef_c}));
      end
      if (gap_left > 0 || drain_pause || pending_sets.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_ch.valid <= 1'b1;
        {in_ch.coef_a, in_ch.coef_b, in_ch.coef_c} <= pending_sets.pop_front();
        gap_left <= rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: %p", out_ch.first_value);
        end else begin
          roots_t exp_r;
          roots_t got;
          exp_r = expected_roots.pop_front();
          got = {out_ch.first_value, out_ch.second_value, out_ch.is_complex,
                 out_ch.lead_zero_error, out_ch.saturated};
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
          end
        end
      end
      if (long_hold) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left <= rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("quadratic_root_solver verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_sets.size() != 0 || in_ch.valid || expected_roots.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    coef_set_t s;
    logic [CW-1:0] extremes[5];
    extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 5; i++) begin
      pending_sets.push_back({extremes[i], extremes[(i + 1) % 5], extremes[(i + 3) % 5]});
    end
    pending_sets.push_back({16'h0000, 16'h1234, 16'h5678});
    pending_sets.push_back({16'h0100, 16'hFE00, 16'h0100});
    pending_sets.push_back({16'h0100, 16'h0000, 16'h0100});
    pending_sets.push_back({16'h0100, 16'h0000, 16'hFF00});
    pending_sets.push_back({16'h0001, 16'h7FFF, 16'h0000});
    pending_sets.push_back({16'hFFFF, 16'h8000, 16'h8000});
    pending_sets.push_back({16'h8000, 16'h0000, 16'h7FFF});
    pending_sets.push_back({16'h0001, 16'h0000, 16'h7FFF});
    pending_sets.push_back({16'hFF00, 16'h0300, 16'hFE00});

    for (int n = 0; n < 1800; n++) begin
      s.a = rand_coef();
      s.b = rand_coef();
      s.c = rand_coef();
      pending_sets.push_back(s);
      if (n == 300) begin
        long_hold = 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      if (n == 900) begin
        drain_pause = 1'b1;
        while (expected_roots.size() != 0 || in_ch.valid) @(posedge clk);
        drain_pause = 1'b0;
      end
    end
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver verification clean");
    end else begin
      $display("quadratic_root_solver verification failed");
    end
    $finish;
  end
endmodule
